>>> rtl/core/awsm_pkg.sv
// Shared types and constants for the address window slot mapper.
`timescale 1ns / 1ps
`default_nettype none

package awsm_pkg;

    // default configuration
    localparam int NUM_SLOTS_DEF       = 15;
    localparam int MMIO_FIRST_SLOT_DEF = 8;
    localparam int COUNT_BITS_DEF      = 16;

    // field widths
    localparam int PHYS_W    = 48;
    localparam int LADDR_W   = 32;
    localparam int WIN_SHIFT = 26;
    localparam int CODE_W    = PHYS_W - WIN_SHIFT;
    localparam int WIN_IDX_W = LADDR_W - WIN_SHIFT;
    localparam int SLOT_FW   = 4;

    // memory types programmed into a window
    localparam logic [2:0] TYPE_MEM  = 3'h4;
    localparam logic [2:0] TYPE_MMIO = 3'h6;

    // request opcodes
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_NONE  = 2'd1;
    localparam logic [1:0] STS_PARAM = 2'd2;
    localparam logic [1:0] STS_FULL  = 2'd3;

    // slot change codes
    localparam logic [1:0] CHG_NONE  = 2'd0;
    localparam logic [1:0] CHG_SET   = 2'd1;
    localparam logic [1:0] CHG_CLEAR = 2'd2;

    typedef struct packed {
        logic               op;
        logic [PHYS_W-1:0]  phys_addr;
        logic               is_mmio;
        logic [LADDR_W-1:0] local_addr_in;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_FW-1:0] slot_index;
        logic [LADDR_W-1:0] local_addr_out;
        logic [1:0]         slot_change;
        logic [CODE_W-1:0]  window_base_code;
        logic [2:0]         mem_type_out;
    } rsp_t;

    // lookup into the slot tag array
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic               mmio;
        logic [SLOT_FW-1:0] uslot;
    } tag_query_t;

    typedef struct packed {
        logic               found;
        logic [SLOT_FW-1:0] fslot;
        logic               fvalid;
        logic               uvalid;
    } tag_result_t;

    // tag write-back
    typedef struct packed {
        logic               set;
        logic               clr;
        logic [SLOT_FW-1:0] slot;
        logic [CODE_W-1:0]  code;
        logic               mmio;
    } tag_update_t;

endpackage

`default_nettype wire

>>> rtl/core/awsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module awsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/awsm_tags.sv
// Slot tag array (valid, window base, type) with parallel first-fit search.
`timescale 1ns / 1ps
`default_nettype none

module awsm_tags #(
    parameter int NUM_SLOTS       = awsm_pkg::NUM_SLOTS_DEF,
    parameter int MMIO_FIRST_SLOT = awsm_pkg::MMIO_FIRST_SLOT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire awsm_pkg::tag_query_t  query,
    output awsm_pkg::tag_result_t      result,
    input  wire awsm_pkg::tag_update_t update
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0]          valid_reg;
    logic [awsm_pkg::CODE_W-1:0]   base_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]          mmio_reg;
    logic [NUM_SLOTS-1:0]          cand;
    logic [SLOT_W-1:0]             fslot;
    logic [SLOT_W-1:0]             uslot;
    logic [SLOT_W-1:0]             wslot;

    assign uslot = query.uslot[SLOT_W-1:0];
    assign wslot = update.slot[SLOT_W-1:0];

    // free or same base and type, only at or above the start slot
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            cand[i] = (!query.mmio || (i >= MMIO_FIRST_SLOT)) &&
                      (!valid_reg[i] ||
                       ((base_reg[i] == query.code) && (mmio_reg[i] == query.mmio)));
        end
    end

    // lowest candidate wins
    always_comb begin
        fslot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                fslot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        result.found  = |cand;
        result.fslot  = awsm_pkg::SLOT_FW'(fslot);
        result.fvalid = valid_reg[fslot];
        result.uvalid = valid_reg[uslot];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (update.set) begin
            valid_reg[wslot] <= 1'b1;
        end else if (update.clr) begin
            valid_reg[wslot] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (update.set) begin
            base_reg[wslot] <= update.code;
            mmio_reg[wslot] <= update.mmio;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/address_window_slot_mapper.sv
// Top level: reference-counted 64 MiB address window slot mapper.
//
//   channel  | ports                    | beat
//   ---------+--------------------------+-------------------------------
//   request  | s_valid s_ready s_data   | awsm_pkg::req_t (map / unmap)
//   result   | m_valid m_ready m_data   | awsm_pkg::rsp_t (one per request)
//
// The accept cycle does the parallel tag search and issues the count RAM read;
// the ST_EXEC state then does the count update, the tag write-back and loads
// the output register.
// Reset clears the slot valid bits, the table-ready flag and the FSM; the
// count RAM is not cleared, an invalid slot reads its count as zero.
// A new request is taken while a result still waits in the output register;
// ST_EXEC holds only while that register is full and not drained.
`timescale 1ns / 1ps
`default_nettype none

module address_window_slot_mapper #(
    parameter int NUM_SLOTS       = awsm_pkg::NUM_SLOTS_DEF,
    parameter int MMIO_FIRST_SLOT = awsm_pkg::MMIO_FIRST_SLOT_DEF,
    parameter int COUNT_BITS      = awsm_pkg::COUNT_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire awsm_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output awsm_pkg::rsp_t      m_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                           accept;
    logic                           out_load;
    logic                           table_ready_reg;

    // search side
    awsm_pkg::tag_query_t           query;
    awsm_pkg::tag_result_t          tres;
    awsm_pkg::tag_update_t          tupd;
    logic [awsm_pkg::WIN_IDX_W-1:0] win_idx;
    logic                           bad_ptr;

    // request held for the ST_EXEC state
    logic                           op_reg;
    logic [awsm_pkg::CODE_W-1:0]    code_reg;
    logic [awsm_pkg::WIN_SHIFT-1:0] off_reg;
    logic                           mmio_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic                           found_reg;
    logic                           valid_reg;
    logic                           bad_reg;
    logic                           ready_reg;

    // count RAM
    logic                           ram_we;
    logic [COUNT_BITS-1:0]          ram_wdata;
    logic [SLOT_W-1:0]              ram_raddr;
    logic [COUNT_BITS-1:0]          ram_rdata;
    logic [COUNT_BITS-1:0]          refs;
    logic [COUNT_BITS-1:0]          refs_dec;

    awsm_pkg::rsp_t                 rsp;
    awsm_pkg::rsp_t                 m_data_reg;
    logic                           m_valid_reg, m_valid_next;

    // no beat is taken while reset is held
    assign s_ready  = (state_reg == ST_IDLE) && aresetn;
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // unmap slot: window number minus one, modulo 64
    assign win_idx = s_data.local_addr_in[awsm_pkg::LADDR_W-1:awsm_pkg::WIN_SHIFT]
                     - awsm_pkg::WIN_IDX_W'(1);
    assign bad_ptr = (win_idx >= awsm_pkg::WIN_IDX_W'(NUM_SLOTS));

    always_comb begin
        query.code  = s_data.phys_addr[awsm_pkg::PHYS_W-1:awsm_pkg::WIN_SHIFT];
        query.mmio  = s_data.is_mmio;
        query.uslot = awsm_pkg::SLOT_FW'(win_idx[SLOT_W-1:0]);
    end

    awsm_tags #(
        .NUM_SLOTS       (NUM_SLOTS),
        .MMIO_FIRST_SLOT (MMIO_FIRST_SLOT)
    ) u_tags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .query   (query),
        .result  (tres),
        .update  (tupd)
    );

    assign ram_raddr = (s_data.op == awsm_pkg::OP_MAP) ? tres.fslot[SLOT_W-1:0]
                                                       : win_idx[SLOT_W-1:0];

    awsm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_refs (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // capture the request and the search outcome
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_data.op;
            code_reg  <= s_data.phys_addr[awsm_pkg::PHYS_W-1:awsm_pkg::WIN_SHIFT];
            off_reg   <= s_data.phys_addr[awsm_pkg::WIN_SHIFT-1:0];
            mmio_reg  <= s_data.is_mmio;
            slot_reg  <= ram_raddr;
            found_reg <= tres.found;
            valid_reg <= (s_data.op == awsm_pkg::OP_MAP) ? tres.fvalid : tres.uvalid;
            bad_reg   <= bad_ptr;
            ready_reg <= table_ready_reg;
        end
    end

    // a free slot always reads as a zero count
    assign refs     = valid_reg ? ram_rdata : '0;
    assign refs_dec = refs - COUNT_BITS'(1);

    always_comb begin
        rsp       = '0;
        ram_we    = 1'b0;
        ram_wdata = refs + COUNT_BITS'(1);
        tupd      = '0;
        tupd.slot = awsm_pkg::SLOT_FW'(slot_reg);
        tupd.code = code_reg;
        tupd.mmio = mmio_reg;

        if (op_reg == awsm_pkg::OP_MAP) begin
            if (!found_reg) begin
                rsp.status = awsm_pkg::STS_NONE;
            end else begin
                rsp.slot_index = awsm_pkg::SLOT_FW'(slot_reg);
                if (valid_reg && (&refs)) begin
                    rsp.status = awsm_pkg::STS_FULL;
                end else begin
                    rsp.status         = awsm_pkg::STS_OK;
                    ram_we             = out_load;
                    rsp.local_addr_out = {awsm_pkg::WIN_IDX_W'(slot_reg)
                                              + awsm_pkg::WIN_IDX_W'(1), off_reg};
                    if (!valid_reg) begin
                        tupd.set             = out_load;
                        rsp.slot_change      = awsm_pkg::CHG_SET;
                        rsp.window_base_code = code_reg;
                        rsp.mem_type_out     = mmio_reg ? awsm_pkg::TYPE_MMIO
                                                        : awsm_pkg::TYPE_MEM;
                    end
                end
            end
        end else begin
            if (!ready_reg) begin
                rsp.status = awsm_pkg::STS_NONE;
            end else if (bad_reg) begin
                rsp.status = awsm_pkg::STS_PARAM;
            end else begin
                rsp.slot_index = awsm_pkg::SLOT_FW'(slot_reg);
                if (refs == '0) begin
                    rsp.status = awsm_pkg::STS_PARAM;
                end else begin
                    rsp.status = awsm_pkg::STS_OK;
                    ram_we     = out_load;
                    ram_wdata  = refs_dec;
                    if (refs_dec == '0) begin
                        tupd.clr        = out_load;
                        rsp.slot_change = awsm_pkg::CHG_CLEAR;
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            table_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept && (s_data.op == awsm_pkg::OP_MAP)) begin
                table_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= rsp;
        end
    end

    // a result only appears out of the update cycle
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without an update cycle");

    // the search of the next request must see the written-back tags
    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken during update cycle");

    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status != awsm_pkg::STS_OK))
            |-> (m_data_reg.local_addr_out == '0) &&
                (m_data_reg.slot_change == awsm_pkg::CHG_NONE))
        else $error("failed request carries an address or slot change");

    a_set_type: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.slot_change == awsm_pkg::CHG_SET))
            |-> ((m_data_reg.mem_type_out == awsm_pkg::TYPE_MEM) ||
                 (m_data_reg.mem_type_out == awsm_pkg::TYPE_MMIO)))
        else $error("new slot without a memory type");

endmodule

`default_nettype wire

>>> verif/address_window_slot_mapper_checker.sv
// Result checker for the address window slot mapper: window table model and beat compare.
`timescale 1ns / 1ps

module address_window_slot_mapper_checker #(
    parameter int NUM_SLOTS       = awsm_pkg::NUM_SLOTS_DEF,
    parameter int MMIO_FIRST_SLOT = awsm_pkg::MMIO_FIRST_SLOT_DEF,
    parameter int COUNT_BITS      = awsm_pkg::COUNT_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  awsm_pkg::req_t  s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  awsm_pkg::rsp_t  m_data,
    input  logic            end_of_test,
    output int              fail_count
);
    import awsm_pkg::*;

    localparam logic [LADDR_W-1:0] LOCAL_BASE  = 32'h0400_0000;
    localparam int                 MAX_REPORTS = 40;

    logic                  win_valid [NUM_SLOTS];
    logic [CODE_W-1:0]     win_code  [NUM_SLOTS];
    logic [2:0]            win_type  [NUM_SLOTS];
    logic [COUNT_BITS-1:0] win_refs  [NUM_SLOTS];
    logic                  table_live;

    rsp_t pending_results[$];
    rsp_t want;
    int   mismatches = 0;
    int   beat_no    = 0;
    logic end_seen   = 1'b0;

    assign fail_count = mismatches;

    function automatic void clear_windows();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            win_valid[i] = 1'b0;
            win_code[i]  = '0;
            win_type[i]  = '0;
            win_refs[i]  = '0;
        end
    endfunction

    function automatic rsp_t predict_window_op(input req_t r);
        rsp_t                 res;
        logic [CODE_W-1:0]    code;
        logic [2:0]           wtype;
        logic [WIN_IDX_W-1:0] widx;
        int                   hit;
        int                   slot;
        res = '0;
        if (r.op == OP_MAP) begin
            code  = r.phys_addr[PHYS_W-1:WIN_SHIFT];
            wtype = r.is_mmio ? TYPE_MMIO : TYPE_MEM;
            hit   = -1;
            if (!table_live) begin
                clear_windows();
                table_live = 1'b1;
            end
            // first slot that is free or already holds this window
            for (int i = (r.is_mmio ? MMIO_FIRST_SLOT : 0); i < NUM_SLOTS; i++) begin
                if (hit < 0 && (!win_valid[i] || (win_code[i] == code && win_type[i] == wtype)))
                    hit = i;
            end
            if (hit < 0) begin
                res.status = STS_NONE;
            end else begin
                res.slot_index = SLOT_FW'(hit);
                if (win_valid[hit] && win_refs[hit] == '1) begin
                    res.status = STS_FULL;
                end else begin
                    if (!win_valid[hit]) begin
                        win_valid[hit]       = 1'b1;
                        win_code[hit]        = code;
                        win_type[hit]        = wtype;
                        win_refs[hit]        = '0;
                        res.slot_change      = CHG_SET;
                        res.window_base_code = code;
                        res.mem_type_out     = wtype;
                    end
                    win_refs[hit] = win_refs[hit] + 1'b1;
                    res.local_addr_out = LOCAL_BASE + (LADDR_W'(hit) << WIN_SHIFT)
                                       + LADDR_W'(r.phys_addr[WIN_SHIFT-1:0]);
                end
            end
        end else begin
            // window index 1 is slot 0; index 0 wraps to 63
            widx = r.local_addr_in[LADDR_W-1:WIN_SHIFT] - 1'b1;
            if (!table_live) begin
                res.status = STS_NONE;
            end else if (int'(widx) >= NUM_SLOTS) begin
                res.status = STS_PARAM;
            end else begin
                slot = int'(widx);
                res.slot_index = SLOT_FW'(slot);
                if (win_refs[slot] == '0) begin
                    res.status = STS_PARAM;
                end else begin
                    win_refs[slot] = win_refs[slot] - 1'b1;
                    if (win_refs[slot] == '0) begin
                        win_valid[slot] = 1'b0;
                        win_code[slot]  = '0;
                        win_type[slot]  = '0;
                        res.slot_change = CHG_CLEAR;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: result beat %0d: %s", $time, beat_no, what);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is 0x%0h, should be 0x%0h", field, got, exp_val));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_windows();
            table_live = 1'b0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no request outstanding");
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(m_data.status), 32'(want.status));
                    check_field("slot_index", 32'(m_data.slot_index), 32'(want.slot_index));
                    check_field("local_addr_out", m_data.local_addr_out,
                                want.local_addr_out);
                    check_field("slot_change", 32'(m_data.slot_change),
                                32'(want.slot_change));
                    check_field("window_base_code", 32'(m_data.window_base_code),
                                32'(want.window_base_code));
                    check_field("mem_type_out", 32'(m_data.mem_type_out),
                                32'(want.mem_type_out));
                end
                beat_no++;
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_window_op(s_data));
            if (end_of_test && !end_seen) begin
                end_seen = 1'b1;
                if (pending_results.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              pending_results.size()));
            end
        end
    end

endmodule

>>> verif/address_window_slot_mapper_tb.sv
// Testbench top for the address window slot mapper: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module address_window_slot_mapper_tb;
    import awsm_pkg::*;

    localparam int NUM_SLOTS       = NUM_SLOTS_DEF;
    localparam int MMIO_FIRST_SLOT = MMIO_FIRST_SLOT_DEF;
    localparam int COUNT_BITS      = COUNT_BITS_DEF;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1800;
    localparam int POOL_SIZE    = 24;   // window bases reused so maps hit live slots
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS   = 8_000_000;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic aclk        = 1'b0;
    logic aresetn     = 1'b0;
    logic s_valid     = 1'b0;
    req_t s_data      = '0;
    logic m_ready     = 1'b0;
    logic end_of_test = 1'b0;
    logic s_ready;
    logic m_valid;
    rsp_t m_data;
    int   fail_count;

    // handshake bookkeeping, sampled at the rising edge, read at the falling edge
    logic s_fire    = 1'b0;
    int   sent_cnt  = 0;
    int   got_cnt   = 0;

    // receiver control
    int       hold_req   = 0;
    int       hold_taken = 0;
    int       hold_left  = 0;
    rx_mode_t rx_mode    = RX_ALWAYS;
    int       rx_left    = 0;
    int       rx_tick    = 0;

    logic [CODE_W-1:0] win_pool [POOL_SIZE];

    always #1 aclk = ~aclk;

    address_window_slot_mapper #(
        .NUM_SLOTS      (NUM_SLOTS),
        .MMIO_FIRST_SLOT(MMIO_FIRST_SLOT),
        .COUNT_BITS     (COUNT_BITS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    address_window_slot_mapper_checker #(
        .NUM_SLOTS      (NUM_SLOTS),
        .MMIO_FIRST_SLOT(MMIO_FIRST_SLOT),
        .COUNT_BITS     (COUNT_BITS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .end_of_test(end_of_test),
        .fail_count (fail_count)
    );

    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
        if (s_valid && s_ready)
            sent_cnt <= sent_cnt + 1;
        if (m_valid && m_ready)
            got_cnt <= got_cnt + 1;
    end

    // Receiver: a long hold-off when the stimulus asks for one, otherwise a
    // mode drawn at random and drawn anew when its random run ends (always ready,
    // coin flip, mostly stalled, periodic).
    always @(negedge aclk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left  = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= (rx_tick % 4 != 3);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    function automatic logic [WIN_SHIFT-1:0] rnd_offset();
        return WIN_SHIFT'($urandom);
    endfunction

    // local address inside the window of a slot
    function automatic logic [LADDR_W-1:0] window_addr(input int slot,
                                                       input logic [WIN_SHIFT-1:0] off);
        logic [WIN_IDX_W-1:0] widx;
        widx = WIN_IDX_W'(slot + 1);
        return {widx, off};
    endfunction

    // unused fields carry random values; the block has to ignore them
    function automatic req_t map_req(input logic [CODE_W-1:0] code,
                                     input logic [WIN_SHIFT-1:0] off, input logic mmio);
        req_t r;
        r.op            = OP_MAP;
        r.phys_addr     = {code, off};
        r.is_mmio       = mmio;
        r.local_addr_in = $urandom;
        return r;
    endfunction

    function automatic req_t unmap_req(input logic [LADDR_W-1:0] la);
        req_t        r;
        logic [63:0] rnd;
        rnd             = {$urandom, $urandom};
        r.op            = OP_UNMAP;
        r.phys_addr     = rnd[PHYS_W-1:0];
        r.is_mmio       = 1'($urandom_range(0, 1));
        r.local_addr_in = la;
        return r;
    endfunction

    // Mostly well-formed traffic: maps to a small set of bases (so counts climb
    // and slots get shared) and unmaps aimed at real slot windows; the rest is
    // fully random addresses, which mostly land on bad pointers.
    function automatic req_t random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return map_req(win_pool[$urandom_range(0, POOL_SIZE - 1)], rnd_offset(),
                           ($urandom_range(0, 4) < 2));
        else if (pick < 50)
            return map_req(CODE_W'($urandom), rnd_offset(), 1'($urandom_range(0, 1)));
        else if (pick < 90)
            return unmap_req(window_addr($urandom_range(0, NUM_SLOTS - 1), rnd_offset()));
        else
            return unmap_req($urandom);
    endfunction

    // Raise valid with the beat and hold it until accepted. Returns at the
    // falling edge after acceptance, so the caller may drive the next beat there.
    task automatic send_request(input req_t r);
        s_valid <= 1'b1;
        s_data  <= r;
        do @(negedge aclk); while (!s_fire);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // sender goes quiet until every outstanding result has been taken
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (got_cnt != sent_cnt);
    endtask

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("address_window_slot_mapper_tb failed");
        $finish;
    end

    initial begin : stimulus
        int left;
        int burst;

        win_pool[0] = '0;
        win_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            win_pool[i] = CODE_W'($urandom);

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        send_request(unmap_req(window_addr(0, '0)));      // unmap before any map
        send_request(map_req('0, '0, 1'b0));              // first map, slot 0 set up
        send_request(map_req('0, '1, 1'b0));              // same window, top offset
        send_request(map_req('1, '1, 1'b1));              // MMIO, all ones -> slot 8
        send_request(map_req('1, '1, 1'b0));              // same base, other type
        send_request(unmap_req(32'h0000_0000));           // bad pointer, index wraps
        send_request(unmap_req(32'h4000_0000));           // one past the last slot
        send_request(unmap_req(32'hFFFF_FFFF));           // bad pointer, all ones
        send_request(unmap_req(window_addr(5, rnd_offset())));  // zero count
        send_request(unmap_req(window_addr(0, '1)));      // count 2 -> 1
        send_request(unmap_req(window_addr(0, '0)));      // count 1 -> 0, slot cleared
        send_request(unmap_req(window_addr(0, '0)));      // zero count after clear
        send_request(unmap_req(window_addr(NUM_SLOTS - 1, '1)));
        // fill the MMIO range; the last map finds no free slot
        for (int i = 1; i <= NUM_SLOTS - MMIO_FIRST_SLOT; i++)
            send_request(map_req(CODE_W'(i), rnd_offset(), 1'b1));

        // sender pauses until every result is back
        wait_results_drained();

        // --- backpressure: receiver holds off while the sender keeps going ---
        hold_req <= hold_req + 1;
        repeat (12) send_request(random_request());

        // --- random part, bursty sender ---
        left = RANDOM_ITEMS;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_request(random_request());
                left--;
            end
            if ($urandom_range(0, 99) == 0)
                wait_results_drained();
            else if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(negedge aclk);
        if (fail_count == 0) begin
            $display("address_window_slot_mapper_tb passed");
        end else begin
            $display("address_window_slot_mapper_tb failed");
        end
        $finish;
    end

endmodule

>>> address_window_slot_mapper.f
rtl/core/awsm_pkg.sv
rtl/core/awsm_ram.sv
rtl/core/awsm_tags.sv
rtl/core/address_window_slot_mapper.sv
verif/address_window_slot_mapper_checker.sv
verif/address_window_slot_mapper_tb.sv
